FILE: rtl/alps_pkg.sv
// ----------------------------------------------------------------------------
// alps_pkg
// Shared types, codes and defaults for the LED pulse serializer.
// ----------------------------------------------------------------------------
package alps_pkg;

    localparam int REPEAT_WIDTH_DEF = 16;
    localparam int TIMING_WIDTH_DEF = 8;

    // Reset values of the timing registers
    localparam int BIT_PERIOD_RST     = 20;
    localparam int ZERO_HIGH_TIME_RST = 6;
    localparam int ONE_HIGH_TIME_RST  = 10;

    // Configuration register indexes
    localparam logic [1:0] CFG_BIT_PERIOD     = 2'd0;
    localparam logic [1:0] CFG_ZERO_HIGH_TIME = 2'd1;
    localparam logic [1:0] CFG_ONE_HIGH_TIME  = 2'd2;

    localparam logic [3:0] BYTE_BITS   = 4'd8;
    localparam logic [1:0] LAST_COLOUR = 2'd2;   // blue, sent last
    localparam int         QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_BYTE = 2'd1,
        MODE_FILL = 2'd2
    } t_mode;

    // Command class decided by the front stage
    typedef enum logic [1:0] {
        KIND_TICK       = 2'd0,
        KIND_BYTE       = 2'd1,
        KIND_FILL       = 2'd2,
        KIND_FILL_EMPTY = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic        final_byte;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  blue;
    } t_cmd;

endpackage

FILE: rtl/alps_if.sv
// ----------------------------------------------------------------------------
// alps_if
// Valid/ready channels of the LED pulse serializer: items, results, config.
// ----------------------------------------------------------------------------
interface alps_in_if
    import alps_pkg::*;
#(
    parameter int REPEAT_WIDTH = REPEAT_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic [7:0]              data_byte;
    logic                    final_byte;
    logic [7:0]              red;
    logic [7:0]              green;
    logic [7:0]              blue;
    logic [REPEAT_WIDTH-1:0] repeat_count;

    modport source (
        output valid, mode, data_byte, final_byte, red, green, blue, repeat_count,
        input  ready
    );
    modport sink (
        input  valid, mode, data_byte, final_byte, red, green, blue, repeat_count,
        output ready
    );
endinterface

interface alps_out_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic frame_done;
    logic command_dropped;

    modport source (
        output valid, pin_level, busy_res, frame_done, command_dropped,
        input  ready
    );
    modport sink (
        input  valid, pin_level, busy_res, frame_done, command_dropped,
        output ready
    );
endinterface

interface alps_cfg_if
    import alps_pkg::*;
#(
    parameter int TIMING_WIDTH = TIMING_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              index;
    logic [TIMING_WIDTH-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/addressable_led_pulse_serializer_top.sv
// ----------------------------------------------------------------------------
// addressable_led_pulse_serializer_top
// Single-wire pulse-width serializer for chained RGB LEDs.
// ----------------------------------------------------------------------------
// Path: an item passes the decode register, the queue and the result register in
//   that order before its result can transfer.
// Throughput: one item per cycle while o_result is ready; the engine state steps per entry.
// Reset: synchronous, active low; clears all control state and loads the timing
//   registers with 20 / 6 / 10 ticks.
module addressable_led_pulse_serializer_top
    import alps_pkg::*;
#(
    parameter int REPEAT_WIDTH = REPEAT_WIDTH_DEF,
    parameter int TIMING_WIDTH = TIMING_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    alps_in_if.sink    i_item,
    alps_cfg_if.sink   i_cfg,
    alps_out_if.source o_result
);

    localparam int QW = $bits(t_cmd) + REPEAT_WIDTH;

    logic                    w_push_valid;
    logic                    w_push_ready;
    t_cmd                    w_push_cmd;
    logic [REPEAT_WIDTH-1:0] w_push_count;
    logic                    w_pop_valid;
    logic                    w_pop_ready;
    logic [QW-1:0]           w_pop_data;
    t_cmd                    w_pop_cmd;
    logic [REPEAT_WIDTH-1:0] w_pop_count;

    alps_front #(
        .REPEAT_WIDTH (REPEAT_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd),
        .o_push_count (w_push_count)
    );

    alps_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  ({w_push_cmd, w_push_count}),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    assign w_pop_cmd   = t_cmd'(w_pop_data[QW-1:REPEAT_WIDTH]);
    assign w_pop_count = w_pop_data[REPEAT_WIDTH-1:0];

    alps_engine #(
        .REPEAT_WIDTH (REPEAT_WIDTH),
        .TIMING_WIDTH (TIMING_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_cmd   (w_pop_cmd),
        .i_pop_count (w_pop_count),
        .i_cfg       (i_cfg),
        .o_result    (o_result)
    );

endmodule

FILE: rtl/alps_front.sv
// ----------------------------------------------------------------------------
// alps_front
// Input stage: takes items, decodes the mode into a command class.
// ----------------------------------------------------------------------------
module alps_front
    import alps_pkg::*;
#(
    parameter int REPEAT_WIDTH = REPEAT_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    alps_in_if.sink                 i_item,
    output logic                    o_push_valid,
    input  logic                    i_push_ready,
    output t_cmd                    o_push_cmd,
    output logic [REPEAT_WIDTH-1:0] o_push_count
);

    logic                    r_valid;
    t_cmd                    r_cmd;
    logic [REPEAT_WIDTH-1:0] r_count;
    t_cmd                    n_cmd;
    logic                    w_take;

    assign i_item.ready = !r_valid || i_push_ready;
    assign w_take       = i_item.valid && i_item.ready;

    always_comb begin
        n_cmd.data_byte  = i_item.data_byte;
        n_cmd.final_byte = i_item.final_byte;
        n_cmd.green      = i_item.green;
        n_cmd.red        = i_item.red;
        n_cmd.blue       = i_item.blue;
        case (i_item.mode)
            MODE_BYTE: begin
                n_cmd.kind = KIND_BYTE;
            end
            MODE_FILL: begin
                n_cmd.kind = (i_item.repeat_count == '0) ? KIND_FILL_EMPTY : KIND_FILL;
            end
            // tick only, and the unused code
            default: begin
                n_cmd.kind = KIND_TICK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd   <= n_cmd;
            r_count <= i_item.repeat_count;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;
    assign o_push_count = r_count;

endmodule

FILE: rtl/alps_queue.sv
// ----------------------------------------------------------------------------
// alps_queue
// Short FIFO between the decode stage and the pulse engine.
// ----------------------------------------------------------------------------
module alps_queue
    import alps_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: rtl/alps_engine.sv
// ----------------------------------------------------------------------------
// alps_engine
// Pulse engine: timing registers, bit shifter, fill sequencer, result register.
// ----------------------------------------------------------------------------
module alps_engine
    import alps_pkg::*;
#(
    parameter int REPEAT_WIDTH = REPEAT_WIDTH_DEF,
    parameter int TIMING_WIDTH = TIMING_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_pop_valid,
    output logic                    o_pop_ready,
    input  t_cmd                    i_pop_cmd,
    input  logic [REPEAT_WIDTH-1:0] i_pop_count,
    alps_cfg_if.sink                i_cfg,
    alps_out_if.source              o_result
);

    localparam int TW = TIMING_WIDTH;
    localparam int RW = REPEAT_WIDTH;

    // timing registers
    logic [TW-1:0] r_bit_period;
    logic [TW-1:0] r_zero_high;
    logic [TW-1:0] r_one_high;

    // transmit state
    logic [7:0]    r_shift;
    logic [3:0]    r_bits_left;
    logic [TW-1:0] r_tick;
    logic [7:0]    r_colour [3];
    logic [1:0]    r_colour_idx;
    logic [RW-1:0] r_repeats;
    logic          r_ends_frame;
    logic          r_filling;

    logic [7:0]    n_shift;
    logic [3:0]    n_bits_left;
    logic [TW-1:0] n_tick;
    logic [7:0]    n_colour [3];
    logic [1:0]    n_colour_idx;
    logic [RW-1:0] n_repeats;
    logic          n_ends_frame;
    logic          n_filling;

    // result register
    logic r_out_valid;
    logic r_out_pin;
    logic r_out_busy;
    logic r_out_done;
    logic r_out_dropped;
    logic n_pin;
    logic n_busy;
    logic n_done;
    logic n_dropped;

    logic          w_idle;
    logic          w_pop;
    logic [TW-1:0] w_high;
    logic [TW-1:0] w_tick_inc;
    logic [7:0]    w_next_colour;

    assign i_cfg.ready = 1'b1;
    assign o_pop_ready = !r_out_valid || o_result.ready;
    assign w_pop       = i_pop_valid && o_pop_ready;
    assign w_idle      = (r_bits_left == '0);

    always_comb begin
        n_shift      = r_shift;
        n_bits_left  = r_bits_left;
        n_tick       = r_tick;
        n_colour     = r_colour;
        n_colour_idx = r_colour_idx;
        n_repeats    = r_repeats;
        n_ends_frame = r_ends_frame;
        n_filling    = r_filling;
        n_pin        = 1'b0;
        n_busy       = 1'b0;
        n_done       = 1'b0;
        n_dropped    = 1'b0;
        w_high        = '0;
        w_tick_inc    = '0;
        w_next_colour = '0;

        // load a command; its first bit runs in this same tick
        case (i_pop_cmd.kind)
            KIND_BYTE: begin
                if (!w_idle) begin
                    n_dropped = 1'b1;
                end else begin
                    n_shift      = i_pop_cmd.data_byte;
                    n_bits_left  = BYTE_BITS;
                    n_tick       = '0;
                    n_ends_frame = i_pop_cmd.final_byte;
                    n_filling    = 1'b0;
                end
            end
            KIND_FILL: begin
                if (!w_idle) begin
                    n_dropped = 1'b1;
                end else begin
                    n_colour[0]  = i_pop_cmd.green;
                    n_colour[1]  = i_pop_cmd.red;
                    n_colour[2]  = i_pop_cmd.blue;
                    n_colour_idx = '0;
                    n_repeats    = i_pop_count;
                    n_filling    = 1'b1;
                    n_ends_frame = 1'b1;
                    n_shift      = i_pop_cmd.green;
                    n_bits_left  = BYTE_BITS;
                    n_tick       = '0;
                end
            end
            KIND_FILL_EMPTY: begin
                if (!w_idle) begin
                    n_dropped = 1'b1;
                end else begin
                    n_done = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // drive one tick of the current bit
        if (n_bits_left != '0) begin
            w_high     = n_shift[7] ? r_one_high : r_zero_high;
            n_busy     = 1'b1;
            n_pin      = (n_tick < w_high);
            w_tick_inc = n_tick + 1'b1;
            if ((w_tick_inc >= r_bit_period) || (w_tick_inc == '0)) begin
                n_tick      = '0;
                n_shift     = {n_shift[6:0], 1'b0};
                n_bits_left = n_bits_left - 1'b1;
                if (n_bits_left == '0) begin
                    if (n_filling) begin
                        // advance to the next colour, wrap after blue
                        if (n_colour_idx == LAST_COLOUR) begin
                            n_colour_idx = '0;
                            n_repeats    = n_repeats - 1'b1;
                        end else begin
                            n_colour_idx = n_colour_idx + 1'b1;
                        end
                        case (n_colour_idx)
                            2'd0:    w_next_colour = n_colour[0];
                            2'd1:    w_next_colour = n_colour[1];
                            default: w_next_colour = n_colour[2];
                        endcase
                        if (n_repeats == '0) begin
                            n_filling    = 1'b0;
                            n_done       = n_ends_frame;
                            n_ends_frame = 1'b0;
                        end else begin
                            n_shift     = w_next_colour;
                            n_bits_left = BYTE_BITS;
                            n_tick      = '0;
                        end
                    end else begin
                        n_done       = n_ends_frame;
                        n_ends_frame = 1'b0;
                    end
                end
            end else begin
                n_tick = w_tick_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= TW'(BIT_PERIOD_RST);
            r_zero_high  <= TW'(ZERO_HIGH_TIME_RST);
            r_one_high   <= TW'(ONE_HIGH_TIME_RST);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BIT_PERIOD:     r_bit_period <= i_cfg.data;
                CFG_ZERO_HIGH_TIME: r_zero_high  <= i_cfg.data;
                CFG_ONE_HIGH_TIME:  r_one_high   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift      <= '0;
            r_bits_left  <= '0;
            r_tick       <= '0;
            r_colour     <= '{default: '0};
            r_colour_idx <= '0;
            r_repeats    <= '0;
            r_ends_frame <= 1'b0;
            r_filling    <= 1'b0;
        end else if (w_pop) begin
            r_shift      <= n_shift;
            r_bits_left  <= n_bits_left;
            r_tick       <= n_tick;
            r_colour     <= n_colour;
            r_colour_idx <= n_colour_idx;
            r_repeats    <= n_repeats;
            r_ends_frame <= n_ends_frame;
            r_filling    <= n_filling;
        end
    end

    // hold the result until the transfer, refill in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_pin     <= n_pin;
            r_out_busy    <= n_busy;
            r_out_done    <= n_done;
            r_out_dropped <= n_dropped;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.pin_level       = r_out_pin;
    assign o_result.busy_res        = r_out_busy;
    assign o_result.frame_done      = r_out_done;
    assign o_result.command_dropped = r_out_dropped;

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_left <= BYTE_BITS)
        else $error("bit counter beyond one byte");

    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bits_left == '0) |-> (r_tick == '0))
        else $error("tick counter running while idle");

    a_fill_has_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filling |-> (r_repeats != '0 && r_bits_left != '0))
        else $error("fill active with nothing left to send");

    a_colour_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_colour_idx != 2'd3)
        else $error("colour index out of range");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && n_dropped) |=> (r_out_busy && r_out_dropped))
        else $error("dropped command reported on an idle tick");

endmodule
